>>> hw/rtl/hsvsq_pkg.sv
// Package for the color command to squared duty block.
// Holds the command and result word types, operation codes and stage types.
// No dependencies.
package hsvsq_pkg;

  // Operation codes carried in the command word.
  localparam logic [1:0] OP_RGB   = 2'd0;
  localparam logic [1:0] OP_HSV   = 2'd1;
  localparam logic [1:0] OP_WHITE = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // White mode offsets only apply from this squared level upward.
  localparam logic [15:0] WHITE_MIN   = 16'd100;
  localparam logic [15:0] GREEN_LIMIT = 16'hFFFF;
  localparam logic [15:0] RED_LIMIT   = 16'hFFFE;

  // Hue sector codes, hue*6 >> 8.
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;

  // Input word.
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
  } cmd_t;

  // Output word.
  typedef struct packed {
    logic [15:0] duty_blue;
    logic [15:0] duty_green;
    logic [15:0] duty_red;
  } duty_t;

  // Control that travels alongside each pipeline stage.
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
  } ctl_t;

  // HSV front end results plus the raw bytes for the other modes.
  typedef struct packed {
    logic [15:0] c;
    logic [15:0] x;
    logic [15:0] m;
    logic [2:0]  sector;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [7:0]  third_byte;
  } front_t;

  // Channel bytes ahead of the gamma map.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } chan_t;

endpackage

>>> hw/rtl/hsvsq_front.sv
// HSV front end: chroma, hue sector and weight, then x and the offset m.
// Two register stages. Depends on hsvsq_pkg.
module hsvsq_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  hsvsq_pkg::cmd_t cmd,
  output hsvsq_pkg::ctl_t ctl,
  output hsvsq_pkg::front_t front
);
  import hsvsq_pkg::*;

  // Stage one registers.
  ctl_t        s1_ctl;
  logic [15:0] s1_c;
  logic [8:0]  s1_w;
  logic [2:0]  s1_sector;
  logic [7:0]  s1_first;
  logic [7:0]  s1_second;
  logic [7:0]  s1_third;

  logic [10:0] hp;
  logic [8:0]  w_next;
  logic [16:0] x_full;
  logic [15:0] m_next;

  // Hue times six; its low nine bits fold into a triangle weight 256-|t|.
  assign hp = 11'({3'd0, cmd.first_byte} * 11'd6);
  assign w_next = hp[8] ? (9'd256 - {1'b0, hp[7:0]}) : {1'b0, hp[7:0]};

  // Stage one: chroma product and hue decode.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
    end else begin
      s1_ctl.valid <= start;
    end
    s1_ctl.op <= cmd.operation;
    s1_c      <= 16'(cmd.third_byte * cmd.second_byte);
    s1_w      <= w_next;
    s1_sector <= hp[10:8];
    s1_first  <= cmd.first_byte;
    s1_second <= cmd.second_byte;
    s1_third  <= cmd.third_byte;
  end

  // Second product and the base level m, which wraps when value is zero.
  assign x_full = {1'b0, s1_c[15:8]} * s1_w;
  assign m_next = {s1_third, 8'h00} - s1_c - 16'd1;

  // Stage two.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= s1_ctl.valid;
    end
    ctl.op            <= s1_ctl.op;
    front.c           <= s1_c;
    front.x           <= x_full[15:0];
    front.m           <= m_next;
    front.sector      <= s1_sector;
    front.first_byte  <= s1_first;
    front.second_byte <= s1_second;
    front.third_byte  <= s1_third;
  end

  // Hue times six never reaches a sector code above five.
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    ctl.valid |-> front.sector <= SEC_5)
    else $error("hue sector out of range");

endmodule

>>> hw/rtl/hsvsq_chan_sel.sv
// Channel select: forms the blue, green and red bytes for every mode.
// One register stage. Depends on hsvsq_pkg.
module hsvsq_chan_sel (
  input  logic              clk,
  input  logic              rst,
  input  hsvsq_pkg::ctl_t   ctl_in,
  input  hsvsq_pkg::front_t front,
  output hsvsq_pkg::ctl_t   ctl,
  output hsvsq_pkg::chan_t  chan
);
  import hsvsq_pkg::*;

  logic [15:0] r1;
  logic [15:0] g1;
  logic [15:0] b1;
  logic [16:0] r_sum;
  logic [16:0] g_sum;
  logic [16:0] b_sum;
  chan_t       chan_next;

  // Sector table: place chroma and x on the channels.
  always_comb begin
    unique case (front.sector)
      SEC_1: begin
        r1 = front.x; g1 = front.c; b1 = 16'd0;
      end
      SEC_2: begin
        r1 = 16'd0; g1 = front.c; b1 = front.x;
      end
      SEC_3: begin
        r1 = 16'd0; g1 = front.x; b1 = front.c;
      end
      SEC_4: begin
        r1 = front.x; g1 = 16'd0; b1 = front.c;
      end
      SEC_5: begin
        r1 = front.c; g1 = 16'd0; b1 = front.x;
      end
      default: begin
        r1 = front.c; g1 = front.x; b1 = 16'd0;
      end
    endcase
  end

  // Add the base level; the byte is bits 15:8 of the sum.
  assign r_sum = {1'b0, front.m} + {1'b0, r1};
  assign g_sum = {1'b0, front.m} + {1'b0, g1};
  assign b_sum = {1'b0, front.m} + {1'b0, b1};

  // Pick the bytes for the mode in hand.
  always_comb begin
    unique case (ctl_in.op)
      OP_RGB: begin
        chan_next.blue  = front.third_byte;
        chan_next.green = front.second_byte;
        chan_next.red   = front.first_byte;
      end
      OP_HSV: begin
        chan_next.blue  = b_sum[15:8];
        chan_next.green = g_sum[15:8];
        chan_next.red   = r_sum[15:8];
      end
      OP_WHITE: begin
        chan_next.blue  = front.first_byte;
        chan_next.green = front.first_byte;
        chan_next.red   = front.first_byte;
      end
      default: begin
        chan_next.blue  = 8'd0;
        chan_next.green = 8'd0;
        chan_next.red   = 8'd0;
      end
    endcase
  end

  // Stage three.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= ctl_in.valid;
    end
    ctl.op <= ctl_in.op;
    chan   <= chan_next;
  end

endmodule

>>> hw/rtl/hsvsq_gamma.sv
// Gamma map (x+1)^2-1 on three channels, then white offsets and output register.
// Two register stages. Depends on hsvsq_pkg.
module hsvsq_gamma (
  input  logic             clk,
  input  logic             rst,
  input  hsvsq_pkg::ctl_t  ctl_in,
  input  hsvsq_pkg::chan_t chan,
  output logic             done,
  output hsvsq_pkg::duty_t result
);
  import hsvsq_pkg::*;

  ctl_t        s4_ctl;
  logic [15:0] s4_blue;
  logic [15:0] s4_green;
  logic [15:0] s4_red;
  logic [8:0]  blue_p1;
  logic [8:0]  green_p1;
  logic [8:0]  red_p1;
  logic [17:0] blue_sq;
  logic [17:0] green_sq;
  logic [17:0] red_sq;
  duty_t       result_next;

  // Square of byte plus one, less one, modulo 2^16.
  assign blue_p1  = {1'b0, chan.blue} + 9'd1;
  assign green_p1 = {1'b0, chan.green} + 9'd1;
  assign red_p1   = {1'b0, chan.red} + 9'd1;
  assign blue_sq  = blue_p1 * blue_p1;
  assign green_sq = green_p1 * green_p1;
  assign red_sq   = red_p1 * red_p1;

  // Stage four.
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_ctl.valid <= 1'b0;
    end else begin
      s4_ctl.valid <= ctl_in.valid;
    end
    s4_ctl.op <= ctl_in.op;
    s4_blue   <= blue_sq[15:0] - 16'd1;
    s4_green  <= green_sq[15:0] - 16'd1;
    s4_red    <= red_sq[15:0] - 16'd1;
  end

  // White adds one on green and two on red from level 100 up, held at the top.
  always_comb begin
    unique case (s4_ctl.op)
      OP_RGB, OP_HSV: begin
        result_next.duty_blue  = s4_blue;
        result_next.duty_green = s4_green;
        result_next.duty_red   = s4_red;
      end
      OP_WHITE: begin
        result_next.duty_blue  = s4_blue;
        result_next.duty_green = (s4_green < WHITE_MIN || s4_green >= GREEN_LIMIT)
                                 ? s4_green : s4_green + 16'd1;
        result_next.duty_red   = (s4_red < WHITE_MIN || s4_red >= RED_LIMIT)
                                 ? s4_red : s4_red + 16'd2;
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  // Stage five: output register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_ctl.valid;
    end
    result <= result_next;
  end

  // White offsets never lower a channel below the one before it.
  a_white_order: assert property (@(posedge clk) disable iff (rst)
    done && $past(s4_ctl.op) == OP_WHITE |->
      result.duty_green >= result.duty_blue && result.duty_red >= result.duty_green)
    else $error("white offsets out of order");

endmodule

>>> hw/rtl/hsv_rgb_to_squared_pwm_top.sv
// Channel    Signals                Meaning
// command    start, busy, cmd       one color command word, taken when start && !busy
// result     done, result           three 16-bit duty values, held for one cycle
//
// Five register stages: chroma and hue decode, x and base level, channel select,
// squaring, white offsets and output register. A word enters every cycle and its
// result shows on done after them all. busy is always low, since the pipeline never
// backs up; the receiver must take each result in the cycle it appears, which the
// block does nothing to enforce. Synchronous reset clears the valid bits only.
// Depends on hsvsq_pkg, hsvsq_front, hsvsq_chan_sel and hsvsq_gamma.
module hsv_rgb_to_squared_pwm_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  hsvsq_pkg::cmd_t  cmd,
  output logic             done,
  output hsvsq_pkg::duty_t result
);
  import hsvsq_pkg::*;

  ctl_t   front_ctl;
  front_t front;
  ctl_t   sel_ctl;
  chan_t  chan;

  // No stage ever holds, so a word is always welcome.
  assign busy = 1'b0;

  hsvsq_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .ctl   (front_ctl),
    .front (front)
  );

  hsvsq_chan_sel u_chan_sel (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (front_ctl),
    .front  (front),
    .ctl    (sel_ctl),
    .chan   (chan)
  );

  hsvsq_gamma u_gamma (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (sel_ctl),
    .chan   (chan),
    .done   (done),
    .result (result)
  );

  // Every accepted word gives its result on done once through the pipeline registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##5 done)
    else $error("result missing after accepted word");

  // No result appears on done without a matching accepted word.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 5))
    else $error("result without a matching word");

endmodule
